// ===== rtl/dtti_pkg.sv =====
// dtti_pkg: shared types, character codes and limit tables for the
// decimal text to integer converter. No dependencies.
`timescale 1ns / 1ps

package dtti_pkg;

  // ascii codes used by the parser
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  // configuration port widths and register indexes
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CfgWidthSelect = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIsSigned    = 1'b1;

  // target width codes
  localparam logic [1:0] WSel8  = 2'd0;
  localparam logic [1:0] WSel16 = 2'd1;
  localparam logic [1:0] WSel32 = 2'd2;
  localparam logic [1:0] WSel64 = 2'd3;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_DIGIT,
    CLS_SPACE,
    CLS_MINUS,
    CLS_PLUS,
    CLS_OTHER
  } char_class_e;

  // one classified character as held in the queue
  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        last;
  } cls_item_t;

  typedef struct packed {
    logic [1:0] width_sel;
    logic       signed_mode;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    logic pop;
    logic pop_last;
  } back_stat_t;

  // magnitude limit with its quotient and remainder by ten
  typedef struct packed {
    logic [63:0] lim;
    logic [63:0] quo;
    logic [3:0]  rem;
  } lim_t;

  function automatic lim_t limit_for(logic [1:0] wsel, logic sgn, logic neg);
    lim_t l;
    l = '0;
    if (!sgn) begin
      case (wsel)
        WSel8:   l = '{64'd255, 64'd25, 4'd5};
        WSel16:  l = '{64'd65535, 64'd6553, 4'd5};
        WSel32:  l = '{64'd4294967295, 64'd429496729, 4'd5};
        default: l = '{64'd18446744073709551615, 64'd1844674407370955161, 4'd5};
      endcase
    end else if (neg) begin
      case (wsel)
        WSel8:   l = '{64'd128, 64'd12, 4'd8};
        WSel16:  l = '{64'd32768, 64'd3276, 4'd8};
        WSel32:  l = '{64'd2147483648, 64'd214748364, 4'd8};
        default: l = '{64'd9223372036854775808, 64'd922337203685477580, 4'd8};
      endcase
    end else begin
      case (wsel)
        WSel8:   l = '{64'd127, 64'd12, 4'd7};
        WSel16:  l = '{64'd32767, 64'd3276, 4'd7};
        WSel32:  l = '{64'd2147483647, 64'd214748364, 4'd7};
        default: l = '{64'd9223372036854775807, 64'd922337203685477580, 4'd7};
      endcase
    end
    return l;
  endfunction

endpackage

// ===== rtl/dtti_if.sv =====
// dtti channel interfaces: character input, result output, register writes.
// Depends on dtti_pkg for the configuration port widths.
`timescale 1ns / 1ps

interface dtti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       last_char;
  modport source(output valid, char_code, has_char, last_char, input ready);
  modport sink(input valid, char_code, has_char, last_char, output ready);
endinterface

interface dtti_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic        is_valid;
  modport source(output valid, value_bits, is_valid, input ready);
  modport sink(input valid, value_bits, is_valid, output ready);
endinterface

interface dtti_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dtti_pkg::CfgIdxW-1:0]  index;
  logic [dtti_pkg::CfgDataW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/dtti_front.sv =====
// dtti_front: classifies one incoming character into digit, whitespace,
// sign, other or none when no character is present. Depends on dtti_pkg.
`timescale 1ns / 1ps

module dtti_front (
  input  logic [7:0]          char_code_i,
  input  logic                has_char_i,
  input  logic                last_char_i,
  output dtti_pkg::cls_item_t item_o
);

  logic [7:0] digit_raw;

  assign digit_raw = char_code_i - dtti_pkg::ChZero;

  // character class and digit value
  always_comb begin
    item_o.last  = last_char_i;
    item_o.digit = digit_raw[3:0];
    if (!has_char_i) begin
      item_o.cls = dtti_pkg::CLS_NONE;
    end else if (char_code_i >= dtti_pkg::ChZero && char_code_i <= dtti_pkg::ChNine) begin
      item_o.cls = dtti_pkg::CLS_DIGIT;
    end else if (char_code_i == dtti_pkg::ChSpace ||
                 (char_code_i >= dtti_pkg::ChTab && char_code_i <= dtti_pkg::ChCr)) begin
      item_o.cls = dtti_pkg::CLS_SPACE;
    end else if (char_code_i == dtti_pkg::ChMinus) begin
      item_o.cls = dtti_pkg::CLS_MINUS;
    end else if (char_code_i == dtti_pkg::ChPlus) begin
      item_o.cls = dtti_pkg::CLS_PLUS;
    end else begin
      item_o.cls = dtti_pkg::CLS_OTHER;
    end
  end

endmodule

// ===== rtl/dtti_queue.sv =====
// dtti_queue: short first-in first-out queue of classified characters
// between front and back. Depends on dtti_pkg.
`timescale 1ns / 1ps

module dtti_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  dtti_pkg::cls_item_t   push_item_i,
  output logic                  pop_valid_o,
  input  logic                  pop_i,
  output dtti_pkg::cls_item_t   pop_item_o,
  output dtti_pkg::queue_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  dtti_pkg::cls_item_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                full, empty, push;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full         = (count_q == CntW'(Depth));
  assign empty        = (count_q == '0);
  assign push         = push_valid_i && !full;
  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign stat_o       = '{empty: empty, full: full};

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/dtti_back.sv =====
// dtti_back: parser state, multiply by ten with saturation, and the result
// register with output formatting. Depends on dtti_pkg.
`timescale 1ns / 1ps

module dtti_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtti_pkg::cfg_t       cfg_i,
  input  logic                 item_valid_i,
  input  dtti_pkg::cls_item_t  item_i,
  output logic                 item_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          value_bits_o,
  output logic                 is_valid_o,
  output dtti_pkg::back_stat_t stat_o
);

  logic        body_q, body_d;
  logic [63:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic        stop_q, stop_d;
  logic        inv_q, inv_d;
  logic        seen_q, seen_d;

  logic           out_valid_q, out_valid_d;
  logic [63:0]    res_mag_q;
  logic           res_neg_q;
  logic           res_ok_q;
  dtti_pkg::cfg_t res_cfg_q;

  dtti_pkg::lim_t lim;
  logic           slot_free, pop, load;
  logic           in_body;
  logic [63:0]    acc_x10;
  logic [63:0]    signed_val;

  // pop when the item needs no result slot or the slot is free
  assign slot_free  = !out_valid_q || out_ready_i;
  assign pop        = item_valid_i && (!item_i.last || slot_free);
  assign load       = pop && item_i.last;
  assign item_pop_o = pop;
  assign stat_o     = '{pop: pop, pop_last: load};

  assign lim     = dtti_pkg::limit_for(cfg_i.width_sel, cfg_i.signed_mode, neg_q);
  assign acc_x10 = (acc_q << 3) + (acc_q << 1) + {60'd0, item_i.digit};

  // parser step for the popped character
  always_comb begin
    body_d  = body_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    stop_d  = stop_q;
    inv_d   = inv_q;
    seen_d  = seen_q;
    in_body = 1'b0;
    if (pop && item_i.cls != dtti_pkg::CLS_NONE && !stop_q) begin
      if (!body_q) begin
        body_d = 1'b1;
        case (item_i.cls)
          dtti_pkg::CLS_SPACE: begin
            body_d = 1'b0;
            inv_d  = 1'b1;
          end
          dtti_pkg::CLS_MINUS: begin
            if (cfg_i.signed_mode) begin
              neg_d = 1'b1;
            end else begin
              acc_d  = '0;
              inv_d  = 1'b1;
              stop_d = 1'b1;
            end
          end
          dtti_pkg::CLS_PLUS: begin
            body_d = 1'b1;
          end
          default: begin
            in_body = 1'b1;
          end
        endcase
      end else begin
        in_body = 1'b1;
      end
    end
    if (in_body) begin
      if (item_i.cls != dtti_pkg::CLS_DIGIT) begin
        inv_d  = 1'b1;
        stop_d = 1'b1;
      end else if (acc_q > lim.quo || (acc_q == lim.quo && item_i.digit > lim.rem)) begin
        // overflow saturates at the limit
        acc_d  = lim.lim;
        inv_d  = 1'b1;
        stop_d = 1'b1;
      end else begin
        acc_d  = acc_x10;
        seen_d = 1'b1;
      end
    end
  end

  // parser state, cleared after the last character of a text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q <= 1'b0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      stop_q <= 1'b0;
      inv_q  <= 1'b0;
      seen_q <= 1'b0;
    end else if (load) begin
      body_q <= 1'b0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      stop_q <= 1'b0;
      inv_q  <= 1'b0;
      seen_q <= 1'b0;
    end else begin
      body_q <= body_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      stop_q <= stop_d;
      inv_q  <= inv_d;
      seen_q <= seen_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_mag_q <= acc_d;
      res_neg_q <= neg_d;
      res_ok_q  <= !inv_d && seen_d;
      res_cfg_q <= cfg_i;
    end
  end

  // apply sign, truncate to the target width and extend
  assign signed_val = res_neg_q ? (64'd0 - res_mag_q) : res_mag_q;

  always_comb begin
    case (res_cfg_q.width_sel)
      dtti_pkg::WSel8: begin
        value_bits_o = res_cfg_q.signed_mode ? {{56{signed_val[7]}}, signed_val[7:0]}
                                             : {56'd0, signed_val[7:0]};
      end
      dtti_pkg::WSel16: begin
        value_bits_o = res_cfg_q.signed_mode ? {{48{signed_val[15]}}, signed_val[15:0]}
                                             : {48'd0, signed_val[15:0]};
      end
      dtti_pkg::WSel32: begin
        value_bits_o = res_cfg_q.signed_mode ? {{32{signed_val[31]}}, signed_val[31:0]}
                                             : {32'd0, signed_val[31:0]};
      end
      default: begin
        value_bits_o = signed_val;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign is_valid_o  = res_ok_q;

endmodule

// ===== rtl/decimal_text_to_integer.sv =====
// decimal_text_to_integer: top level with configuration registers, front
// classifier, queue and back parser. Depends on dtti_pkg, dtti_if, dtti_front,
// dtti_queue and dtti_back.
//
//   channel  | dir | payload                          | handshake
//   ---------+-----+----------------------------------+-------------
//   in_i     | in  | char_code, has_char, last_char   | valid/ready
//   out_o    | out | value_bits, is_valid             | valid/ready
//   cfg_i    | in  | index (0 width_select, 1 signed) | valid/ready
//
// One item is accepted per cycle while the queue has room; the back parser
// takes one queued item per cycle through its multiply-by-ten and limit
// compare, but holds a last item while the result register is busy. A
// result is registered in the queue and then in the result register.
// Reset clears queue, parser and result register; width 32 bits, signed.
// An output stall holds the result register; last items then wait in the
// queue, and the input stalls once the queue is full.
`timescale 1ns / 1ps

module decimal_text_to_integer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtti_in_if.sink    in_i,
  dtti_out_if.source out_o,
  dtti_cfg_if.sink   cfg_i
);

  dtti_pkg::cfg_t        cfg_q, cfg_d;
  dtti_pkg::cls_item_t   front_item;
  dtti_pkg::cls_item_t   back_item;
  dtti_pkg::queue_stat_t q_stat;
  dtti_pkg::back_stat_t  b_stat;
  logic                  back_valid;
  logic                  back_pop;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        dtti_pkg::CfgWidthSelect: cfg_d.width_sel   = cfg_i.data[1:0];
        dtti_pkg::CfgIsSigned:    cfg_d.signed_mode = cfg_i.data[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{width_sel: dtti_pkg::WSel32, signed_mode: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify incoming characters
  dtti_front u_front (
    .char_code_i (in_i.char_code),
    .has_char_i  (in_i.has_char),
    .last_char_i (in_i.last_char),
    .item_o      (front_item)
  );

  dtti_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid),
    .push_ready_o (in_i.ready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_i        (back_pop),
    .pop_item_o   (back_item),
    .stat_o       (q_stat)
  );

  dtti_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (back_valid),
    .item_i       (back_item),
    .item_pop_o   (back_pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .value_bits_o (out_o.value_bits),
    .is_valid_o   (out_o.is_valid),
    .stat_o       (b_stat)
  );

`ifndef NO_ASSERTIONS
  // the back stage never takes from an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a result is only loaded into a free or draining result register
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.pop_last |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten");

  // a loaded result is shown in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.pop_last |=> out_o.valid)
    else $error("result not presented");
`endif

endmodule

// ===== tb/sv/decimal_text_to_integer_chk.sv =====
// decimal_text_to_integer_chk: watches the character, result and register
// channels, predicts each parsed number and compares it with the block.
// Depends on dtti_pkg and the dtti channel interfaces.
`timescale 1ns / 1ps

module decimal_text_to_integer_chk
  import dtti_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dtti_in_if   in_ch,
  dtti_out_if  out_ch,
  dtti_cfg_if  cfg_ch,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [63:0] Radix = 64'd10;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        is_valid;
  } number_t;

  // register copy and parser state
  cfg_t        mode;
  logic        in_body;
  logic [63:0] magnitude;
  logic        minus_seen;
  logic        halted;
  logic        spoilt;
  logic        got_digit;

  number_t     parsed_q[$];
  number_t     want;
  int          errors;

  // largest magnitude the target type can hold for the current sign
  function automatic logic [63:0] mag_ceiling(logic [1:0] wsel, logic sgn, logic neg);
    int unsigned w;
    logic [63:0] half;
    w = 8 << wsel;
    half = 64'd1 << (w - 1);
    if (sgn) return neg ? half : half - 64'd1;
    if (w == 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  task automatic clear_text();
    in_body = 1'b0;
    magnitude = '0;
    minus_seen = 1'b0;
    halted = 1'b0;
    spoilt = 1'b0;
    got_digit = 1'b0;
  endtask

  // one character of the text
  task automatic take_text_char(logic [7:0] c);
    logic [63:0] lim;
    logic [63:0] digit;
    if (halted) return;
    if (!in_body) begin
      // leading whitespace is skipped but spoils the result
      if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
        spoilt = 1'b1;
        return;
      end
      in_body = 1'b1;
      if (c == ChMinus) begin
        if (mode.signed_mode) begin
          minus_seen = 1'b1;
        end else begin
          magnitude = '0;
          spoilt = 1'b1;
          halted = 1'b1;
        end
        return;
      end
      if (c == ChPlus) return;
    end
    // any non-digit in the body stops parsing
    if (c < ChZero || c > ChNine) begin
      spoilt = 1'b1;
      halted = 1'b1;
      return;
    end
    digit = 64'(c - ChZero);
    lim = mag_ceiling(mode.width_sel, mode.signed_mode, minus_seen);
    // saturate on overflow
    if (magnitude > lim / Radix || (magnitude == lim / Radix && digit > lim % Radix)) begin
      magnitude = lim;
      spoilt = 1'b1;
      halted = 1'b1;
      return;
    end
    magnitude = magnitude * Radix + digit;
    got_digit = 1'b1;
  endtask

  // end of text: fold sign and width into the raw bits
  task automatic close_text();
    int unsigned w;
    logic [63:0] v;
    logic [63:0] mask;
    v = minus_seen ? 64'd0 - magnitude : magnitude;
    w = 8 << mode.width_sel;
    if (w < 64) begin
      mask = (64'd1 << w) - 64'd1;
      v = v & mask;
      if (mode.signed_mode && v[w-1]) v = v | ~mask;
    end
    parsed_q.push_back('{value_bits: v, is_valid: !spoilt && got_digit});
    clear_text();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode.width_sel = WSel32;
      mode.signed_mode = 1'b1;
      clear_text();
      parsed_q.delete();
      errors = 0;
    end else begin
      // compare each result with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (parsed_q.size() == 0) begin
          $display("%0t: unexpected result value_bits %h is_valid %b", $time,
                   out_ch.value_bits, out_ch.is_valid);
          errors++;
        end else begin
          want = parsed_q.pop_front();
          if (out_ch.value_bits !== want.value_bits) begin
            $display("%0t: value_bits expected %h got %h", $time, want.value_bits,
                     out_ch.value_bits);
            errors++;
          end
          if (out_ch.is_valid !== want.is_valid) begin
            $display("%0t: is_valid expected %b got %b", $time, want.is_valid,
                     out_ch.is_valid);
            errors++;
          end
        end
      end
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CfgWidthSelect) mode.width_sel = cfg_ch.data[1:0];
        else if (cfg_ch.index == CfgIsSigned) mode.signed_mode = cfg_ch.data[0];
      end
      // character items
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.has_char) take_text_char(in_ch.char_code);
        if (in_ch.last_char) close_text();
      end
    end
    fail_count_o <= errors;
    pending_o <= parsed_q.size();
  end

endmodule

// ===== tb/sv/decimal_text_to_integer_tb.sv =====
// decimal_text_to_integer_tb: drives number texts and register settings into
// the converter, with random stalls; decimal_text_to_integer_chk checks results.
// Depends on dtti_pkg, the dtti channel interfaces and the converter RTL.
`timescale 1ns / 1ps

module decimal_text_to_integer_tb;
  import dtti_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned SettleCycles = 8;

  logic clk_i;
  logic rst_ni;

  dtti_in_if  in_ch ();
  dtti_out_if out_ch ();
  dtti_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int items_sent;
  int phase_no;
  int stall_cycles;
  bit calm;
  logic [1:0] wsel;
  logic sgn;
  logic [7:0] text_q[$];

  decimal_text_to_integer uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  decimal_text_to_integer_chk chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side stalls
  always @(posedge clk_i) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 32);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("decimal_text_to_integer_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // type limit, used to aim numbers at the saturation edge
  function automatic logic [63:0] edge_of_type(logic [1:0] ws, logic sg, logic neg);
    int unsigned w;
    w = 8 << ws;
    if (sg) return neg ? (64'd1 << (w - 1)) : (64'd1 << (w - 1)) - 64'd1;
    if (w == 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? ChSpace : 8'(ChTab + r);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(ChZero + $urandom_range(0, 9));
  endfunction

  // one item on the character channel, with random gaps before it
  task automatic send_item(input logic [7:0] c, input logic h, input logic l);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.has_char <= h;
    in_ch.last_char <= l;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (h || l) items_sent++;
    calm <= (items_sent >= 250 && items_sent < 400);
  endtask

  // send text_q as one text; blank_tail marks the end with an empty item
  task automatic send_text(input bit blank_tail);
    if (text_q.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    foreach (text_q[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(text_q[i], 1'b1, (i == text_q.size() - 1) && !blank_tail);
    end
    if (blank_tail) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_str(input string s, input bit blank_tail);
    text_q.delete();
    foreach (s[i]) text_q.push_back(s[i]);
    send_text(blank_tail);
  endtask

  task automatic add_decimal(input logic [67:0] m);
    logic [7:0] digits[$];
    do begin
      digits.push_front(8'(ChZero + m % 68'd10));
      m = m / 68'd10;
    end while (m != 0);
    foreach (digits[i]) text_q.push_back(digits[i]);
  endtask

  // number text, mostly well formed and often near the limits of the target type
  task automatic make_number(input logic [1:0] ws, input logic sg);
    logic neg;
    logic beyond;
    logic [63:0] lim;
    logic [67:0] mag;
    int kind;
    text_q.delete();
    neg = 1'b0;
    beyond = 1'b0;
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(pick_space());
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      neg = 1'b1;
      text_q.push_back(ChMinus);
    end else if (kind < 6) begin
      text_q.push_back(ChPlus);
    end
    if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(ChZero);
    lim = edge_of_type(ws, sg, neg && sg);
    case ($urandom_range(0, 9))
      0, 1, 2: mag = 68'($urandom_range(0, 999));
      3, 4:    mag = {$urandom, $urandom} % ({4'b0, lim} + 68'd1);
      5, 6, 7: mag = {4'b0, lim} - 68'($urandom_range(0, 12));
      8:       mag = {4'b0, lim} + 68'($urandom_range(1, 12));
      default: begin
        mag = {4'b0, lim};
        beyond = 1'b1;
      end
    endcase
    add_decimal(mag);
    if (beyond) repeat ($urandom_range(1, 3)) text_q.push_back(pick_digit());
    // occasional junk after the digits
    if ($urandom_range(0, 9) == 0) begin
      text_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) text_q.push_back(pick_digit());
    end
  endtask

  // short random text of any characters
  task automatic make_noise();
    text_q.delete();
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 3))
        0:       text_q.push_back(8'($urandom_range(0, 255)));
        1:       text_q.push_back(pick_space());
        2:       text_q.push_back($urandom_range(0, 1) ? ChMinus : ChPlus);
        default: text_q.push_back(pick_digit());
      endcase
    end
  endtask

  // wait for all results, then let the pipeline settle
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write both registers, back to back
  task automatic set_mode(input logic [1:0] ws, input logic sg);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CfgWidthSelect;
    cfg_ch.data <= ws;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.index <= CfgIsSigned;
    cfg_ch.data <= {1'($urandom_range(0, 1)), sg};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.has_char <= 1'b0;
    in_ch.last_char <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    calm <= 1'b0;
    items_sent = 0;
    phase_no = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed texts at the reset setting, 32 bit signed
    send_str("", 1'b0);
    send_str(" -7", 1'b0);
    send_str("+0", 1'b0);
    send_str("-", 1'b0);
    send_str("1x", 1'b0);
    send_str("--", 1'b0);
    send_str("9-", 1'b0);
    send_str("\t9", 1'b0);
    send_str("5", 1'b1);
    text_q = '{8'hFF};
    send_text(1'b0);
    text_q = '{8'h00};
    send_text(1'b0);

    // minus and overflow on an 8 bit unsigned target
    quiesce();
    set_mode(WSel8, 1'b0);
    send_str("-5", 1'b0);
    send_str("256", 1'b0);

    // random phases, first through every width and signedness
    while (items_sent < 650 || phase_no < 8) begin
      quiesce();
      if (phase_no < 8) begin
        wsel = 2'(phase_no % 4);
        sgn = (phase_no < 4);
      end else begin
        wsel = 2'($urandom_range(0, 3));
        sgn = 1'($urandom_range(0, 1));
      end
      set_mode(wsel, sgn);
      repeat (7) begin
        if ($urandom_range(0, 9) < 7) make_number(wsel, sgn);
        else make_noise();
        send_text($urandom_range(0, 15) == 0);
      end
      phase_no++;
    end

    quiesce();
    if (fail_count == 0 && pending == 0) begin
      $display("decimal_text_to_integer_tb OK");
    end else begin
      $display("decimal_text_to_integer_tb NOT OK");
    end
    $finish;
  end

endmodule
